// ===== hdl/mmcm_pkg.sv =====
// Shared types and constants for the column-major matrix multiply block.
`default_nettype none
package mmcm_pkg;

	localparam int PROD_W = 35;
	localparam int IDX_W  = 3;
	localparam int IN_W   = 16;
	localparam int DIM_W  = 4;

	typedef enum logic [1:0] {
		ACT_WR_A = 2'd0,
		ACT_WR_B = 2'd1,
		ACT_MUL  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_A_ROWS = 2'd0,
		REG_A_COLS = 2'd1,
		REG_B_ROWS = 2'd2,
		REG_B_COLS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic v_s1;
		logic clr;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/mmcm_cell.sv =====
// One row cell: holds a row of A, multiplies by the broadcast B element, accumulates, shifts out.
`default_nettype none
module mmcm_cell
	import mmcm_pkg::*;
#(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(MAX_DIM)-1:0]    wr_col,
	input  wire logic signed [VALUE_WIDTH-1:0] wr_val,
	input  wire cell_ctrl_t                    ctrl,
	input  wire logic [$clog2(MAX_DIM)-1:0]    x_s1,
	input  wire logic signed [VALUE_WIDTH-1:0] b_s1,
	input  wire logic [PROD_W-1:0]             shift_in,
	output logic [PROD_W-1:0]                  acc_out
);
	localparam int FULL_W = (2 * VALUE_WIDTH > PROD_W) ? 2 * VALUE_WIDTH : PROD_W;

	logic signed [VALUE_WIDTH-1:0] a_q [MAX_DIM];
	logic signed [FULL_W-1:0]      prod_full;
	logic [PROD_W-1:0]             prod_s2;
	logic                          v_s2;
	logic [PROD_W-1:0]             acc_q;

	assign prod_full = a_q[x_s1] * b_s1;
	assign acc_out   = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_DIM; k++) a_q[k] <= '0;
		end else if (wr_en) begin
			a_q[wr_col] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctrl.v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_full[PROD_W-1:0];
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.shift) begin
			acc_q <= shift_in;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/matrix_multiply_column_major.sv =====
// Operation: element writes are stored directly; a multiply steps through each product column, reading
// B and accumulating in the cells, then shifts the column's results out of the cell chain row by row.
// Throughput: one write per cycle; a multiply holds the input off until all results are loaded.
// The B element memory port (one read per cycle) sets the per-column compute time.
// Reset: asynchronous, sizes return to 4, both element stores read as zero.
`default_nettype none
module matrix_multiply_column_major
	import mmcm_pkg::*;
#(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // row[2:0], col[5:3], value[21:6], zero fill
	input  wire logic [1:0]  s_tuser,  // action[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // out_row[2:0], out_col[5:3], product[40:6], zero fill
	output logic [0:0]       m_tuser,  // mismatch[0]
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [3:0]  cfg_data
);
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int BD    = 2 ** (2 * IW);
	localparam int EXT_W = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CALC  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_OUT   = 5'b01000,
		ST_MIS   = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [DIM_W-1:0]        a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DW-1:0]           ar, ac, br, bc;
	logic [DW-1:0]           x_q, j_q, i_q;
	logic [IW-1:0]           x_s1;
	logic                    rd_v_s1, v_s2_q;
	logic                    acc_in;
	action_t                 act;
	logic [IDX_W-1:0]        in_row, in_col;
	logic signed [IN_W-1:0]  in_val;
	logic signed [EXT_W-1:0] ext_val;
	logic signed [VALUE_WIDTH-1:0] wval;
	logic                    wr_a_ok, wr_b_ok;
	logic                    mul_go, mul_ok;
	logic                    load_out, col_done, run_done;
	logic [2*IW-1:0]         b_wa, b_ra;
	logic signed [VALUE_WIDTH-1:0] b_mem [BD];
	logic                    b_vld_q [BD];
	logic signed [VALUE_WIDTH-1:0] b_rd_s1, b_s1;
	logic                    b_vld_s1;
	cell_ctrl_t              ctrl;
	logic [PROD_W-1:0]       acc_w [MAX_DIM+1];

	function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] r);
		logic [DW-1:0] d;
		if (r == '0) d = DW'(1);
		else if (32'(r) > MAX_DIM) d = DW'(MAX_DIM);
		else d = DW'(r);
		return d;
	endfunction

	assign ar = clamp_dim(a_rows_q);
	assign ac = clamp_dim(a_cols_q);
	assign br = clamp_dim(b_rows_q);
	assign bc = clamp_dim(b_cols_q);

	assign act     = action_t'(s_tuser);
	assign in_row  = s_tdata[2:0];
	assign in_col  = s_tdata[5:3];
	assign in_val  = s_tdata[21:6];
	assign ext_val = EXT_W'(in_val);
	assign wval    = ext_val[VALUE_WIDTH-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign wr_a_ok  = acc_in && act == ACT_WR_A && 8'(in_row) < 8'(ar) && 8'(in_col) < 8'(ac);
	assign wr_b_ok  = acc_in && act == ACT_WR_B && 8'(in_row) < 8'(br) && 8'(in_col) < 8'(bc);
	assign mul_go   = acc_in && act == ACT_MUL;
	assign mul_ok   = mul_go && ac == br;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_W'(4);
			a_cols_q <= DIM_W'(4);
			b_rows_q <= DIM_W'(4);
			b_cols_q <= DIM_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_A_ROWS: a_rows_q <= cfg_data;
				REG_A_COLS: a_cols_q <= cfg_data;
				REG_B_ROWS: b_rows_q <= cfg_data;
				REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// B element memory
	assign b_wa = {IW'(in_row), IW'(in_col)};
	assign b_ra = {IW'(x_q), IW'(j_q)};

	always_ff @(posedge clk) begin
		if (wr_b_ok) b_mem[b_wa] <= wval;
		b_rd_s1 <= b_mem[b_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BD; k++) b_vld_q[k] <= 1'b0;
			b_vld_s1 <= 1'b0;
		end else begin
			if (wr_b_ok) b_vld_q[b_wa] <= 1'b1;
			b_vld_s1 <= b_vld_q[b_ra];
		end
	end

	assign b_s1 = b_vld_s1 ? b_rd_s1 : '0;

	assign load_out = !m_tvalid || m_tready;
	assign col_done = (state_q == ST_OUT) && load_out && i_q == ar - 1'b1;
	assign run_done = col_done && j_q == bc - 1'b1;

	assign ctrl.v_s1  = rd_v_s1;
	assign ctrl.clr   = mul_ok || (col_done && !run_done);
	assign ctrl.shift = (state_q == ST_OUT) && load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			x_q      <= '0;
			j_q      <= '0;
			i_q      <= '0;
			rd_v_s1  <= 1'b0;
			v_s2_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_CALC);
			v_s2_q  <= rd_v_s1;
			if (load_out) m_tvalid <= (state_q == ST_OUT) || (state_q == ST_MIS);
			unique case (state_q)
				ST_IDLE: begin
					if (mul_go) begin
						x_q <= '0;
						j_q <= '0;
						state_q <= mul_ok ? ST_CALC : ST_MIS;
					end
				end
				ST_CALC: begin
					x_q <= x_q + 1'b1;
					if (x_q == ac - 1'b1) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !v_s2_q) begin
						i_q <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						if (run_done) begin
							state_q <= ST_IDLE;
						end else if (col_done) begin
							j_q <= j_q + 1'b1;
							x_q <= '0;
							state_q <= ST_CALC;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				ST_MIS: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_OUT) begin
				m_tdata <= {7'd0, acc_w[0], IDX_W'(j_q), IDX_W'(i_q)};
				m_tuser <= 1'b0;
				m_tlast <= run_done;
			end else if (state_q == ST_MIS) begin
				m_tdata <= '0;
				m_tuser <= 1'b1;
				m_tlast <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= IW'(x_q);
	end

	assign acc_w[MAX_DIM] = '0;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		mmcm_cell #(
			.MAX_DIM     (MAX_DIM),
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_a_ok && 8'(in_row) == 8'(g)),
			.wr_col   (IW'(in_col)),
			.wr_val   (wval),
			.ctrl     (ctrl),
			.x_s1     (x_s1),
			.b_s1     (b_s1),
			.shift_in (acc_w[g+1]),
			.acc_out  (acc_w[g])
		);
	end

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !rd_v_s1)
		else $error("input taken while products in flight");
	a_mis_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("mismatch result not marked last");
	a_out_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !rd_v_s1 && !v_s2_q)
		else $error("unload while accumulation pending");
`endif

endmodule
`default_nettype wire

// ===== test/matrix_multiply_column_major_tb.sv =====
// Testbench for the column-major matrix multiply block: directed and random element traffic.
`timescale 1ns / 100ps
`default_nettype none
module matrix_multiply_column_major_tb;
	import mmcm_pkg::*;

	localparam int DIM = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [2:0]        row;
		logic [2:0]        col;
		logic [PROD_W-1:0] prod;
		logic              mis;
		logic              last;
	} product_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [23:0]       s_tdata = '0;
	logic [1:0]        s_tuser = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [47:0]       m_tdata;
	logic [0:0]        m_tuser;
	logic              m_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [3:0]        cfg_data = '0;

	logic signed [15:0] a_mem [DIM][DIM];
	logic signed [15:0] b_mem [DIM][DIM];
	logic [3:0]         dim_reg [4];
	product_t           pending_products [$];
	int                 errors = 0;
	int                 cycles = 0;
	int                 sent_items = 0;
	int                 checked_products = 0;
	int                 mul_runs = 0;
	int                 burst_left = 0;
	int                 stall_mode = 0;

	matrix_multiply_column_major u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int dim_of(logic [3:0] r);
		if (r == 0) return 1;
		if (r > DIM) return DIM;
		return int'(r);
	endfunction

	function automatic void predict_item(action_t act, logic [2:0] r, logic [2:0] c,
			logic [15:0] v);
		int ar, ac, br, bc;
		longint acc;
		product_t p;
		ar = dim_of(dim_reg[REG_A_ROWS]);
		ac = dim_of(dim_reg[REG_A_COLS]);
		br = dim_of(dim_reg[REG_B_ROWS]);
		bc = dim_of(dim_reg[REG_B_COLS]);
		case (act)
			ACT_WR_A: if (r < ar && c < ac) a_mem[r][c] = v;
			ACT_WR_B: if (r < br && c < bc) b_mem[r][c] = v;
			ACT_MUL: begin
				mul_runs++;
				if (ac != br) begin
					p.row = '0; p.col = '0; p.prod = '0; p.mis = 1'b1; p.last = 1'b1;
					pending_products.push_back(p);
				end else begin
					for (int j = 0; j < bc; j++)
						for (int i = 0; i < ar; i++) begin
							acc = 0;
							for (int x = 0; x < ac; x++)
								acc += longint'(a_mem[i][x]) * longint'(b_mem[x][j]);
							p.row = i[2:0];
							p.col = j[2:0];
							p.prod = acc[PROD_W-1:0];
							p.mis = 1'b0;
							p.last = (i == ar - 1 && j == bc - 1);
							pending_products.push_back(p);
						end
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_request(action_t act, logic [2:0] r, logic [2:0] c, logic [15:0] v);
		int gap;
		s_tdata <= {2'b00, v, c, r};
		s_tuser <= act;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_item(act, r, c, v);
		sent_items++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_products.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_size(reg_idx_t idx, logic [3:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dim_reg[idx] = val;
	endtask

	task automatic set_sizes(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
		drain_results();
		write_size(REG_A_ROWS, ar);
		write_size(REG_A_COLS, ac);
		write_size(REG_B_ROWS, br);
		write_size(REG_B_COLS, bc);
	endtask

	task automatic test_extreme_values();
		send_request(ACT_WR_A, 0, 0, 16'h8000);
		send_request(ACT_WR_A, 3, 3, 16'h7fff);
		send_request(ACT_WR_A, 0, 3, 16'h8000);
		send_request(ACT_WR_B, 0, 0, 16'h8000);
		send_request(ACT_WR_B, 3, 3, 16'h7fff);
		send_request(ACT_WR_B, 3, 0, 16'h8000);
		send_request(ACT_WR_B, 2, 1, 16'hffff);
		send_request(ACT_MUL, 0, 0, 16'h0000);
	endtask

	task automatic test_ignored_requests();
		send_request(ACT_WR_A, 4, 0, 16'h1234);
		send_request(ACT_WR_A, 0, 7, 16'h5678);
		send_request(ACT_WR_B, 7, 7, 16'hffff);
		send_request(ACT_NONE, 1, 1, 16'hffff);
		send_request(ACT_MUL, 7, 7, 16'hffff);
	endtask

	task automatic test_size_mismatch();
		set_sizes(4'd2, 4'd3, 4'd4, 4'd2);
		send_request(ACT_MUL, 0, 0, 16'h0000);
	endtask

	task automatic test_clamped_sizes();
		set_sizes(4'd0, 4'd15, 4'd8, 4'd0);
		send_request(ACT_WR_A, 0, 7, 16'h7fff);
		send_request(ACT_WR_B, 7, 0, 16'h7fff);
		send_request(ACT_MUL, 0, 0, 16'h0000);
		set_sizes(4'd15, 4'd8, 4'd8, 4'd8);
		for (int k = 0; k < 8; k++)
			send_request(ACT_WR_A, k[2:0], k[2:0], 16'h8000);
		send_request(ACT_MUL, 0, 0, 16'h0000);
		set_sizes(4'd1, 4'd1, 4'd1, 4'd1);
		send_request(ACT_MUL, 0, 0, 16'h0000);
	endtask

	task automatic test_random_traffic();
		int ar, ac, br, bc, n, sel;
		logic [15:0] v;
		action_t act;
		while (sent_items < 235) begin
			ar = $urandom_range(1, 8);
			ac = $urandom_range(1, 8);
			br = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : ac;
			bc = $urandom_range(1, 8);
			if ($urandom_range(0, 7) == 0) ar = $urandom_range(0, 15);
			set_sizes(ar[3:0], ac[3:0], br[3:0], bc[3:0]);
			n = $urandom_range(4, 30);
			for (int k = 0; k < n; k++) begin
				sel = $urandom_range(0, 15);
				act = (sel < 7) ? ACT_WR_A : (sel < 14) ? ACT_WR_B : (sel == 14) ? ACT_NONE :
					ACT_MUL;
				case ($urandom_range(0, 5))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'($urandom_range(0, 1023) - 512);
					default: v = 16'($urandom_range(0, 65535));
				endcase
				if ($urandom_range(0, 5) == 0)
					send_request(act, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), v);
				else if (act == ACT_WR_B)
					send_request(act, 3'($urandom_range(0, dim_of(br[3:0]) - 1)),
						3'($urandom_range(0, dim_of(bc[3:0]) - 1)), v);
				else
					send_request(act, 3'($urandom_range(0, dim_of(ar[3:0]) - 1)),
						3'($urandom_range(0, dim_of(ac[3:0]) - 1)), v);
			end
			send_request(ACT_MUL, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				16'($urandom_range(0, 65535)));
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 4) == 0);
		endcase
		if (cycles > CYCLE_LIMIT) begin
			$display("[matrix_multiply_column_major] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		product_t p;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_products.size() == 0) begin
				$display("%0t: unexpected product row %0d col %0d data %h", $time,
					m_tdata[2:0], m_tdata[5:3], m_tdata[40:6]);
				errors++;
			end else begin
				p = pending_products.pop_front();
				checked_products++;
				if (m_tdata[2:0] !== p.row || m_tdata[5:3] !== p.col ||
						m_tdata[40:6] !== p.prod || m_tuser[0] !== p.mis ||
						m_tlast !== p.last) begin
					$display("%0t: expected row %0d col %0d prod %h mis %b last %b", $time,
						p.row, p.col, p.prod, p.mis, p.last);
					$display("%0t: actual   row %0d col %0d prod %h mis %b last %b", $time,
						m_tdata[2:0], m_tdata[5:3], m_tdata[40:6], m_tuser[0], m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < DIM; i++)
			for (int j = 0; j < DIM; j++) begin
				a_mem[i][j] = '0;
				b_mem[i][j] = '0;
			end
		for (int i = 0; i < 4; i++) dim_reg[i] = 4'd4;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_values();
		test_ignored_requests();
		test_size_mismatch();
		test_clamped_sizes();
		test_random_traffic();
		drain_results();
		$display("Covered %0d requests, %0d multiply runs, %0d products checked.",
			sent_items, mul_runs, checked_products);
		if (errors == 0)
			$display("[matrix_multiply_column_major] OK");
		else
			$display("[matrix_multiply_column_major] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
